// File: hdl/assert_macros.svh
// Assertion macros shared by the converter RTL.
// Each macro assumes a clock named clk and an active-low reset named rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold in the same cycle as its antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Property whose consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/uyvy_fc_pkg.sv
// Shared types and constants for the 4:2:2 to RGB field converter.
// No dependencies.
package uyvy_fc_pkg;

  localparam int COEF_FRAC_BITS_DEF = 16;

  typedef struct packed {
    logic [31:0] pixel_word;
    logic        frame_start;
    logic        line_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_first;
    logic [7:0] green_first;
    logic [7:0] blue_first;
    logic [7:0] red_second;
    logic [7:0] green_second;
    logic [7:0] blue_second;
    logic       last_of_line;
  } out_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

endpackage

// File: hdl/uyvy_fc_field_gate.sv
// Line parity tracking and output enable register; decides which words are kept.
// Depends on uyvy_fc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module uyvy_fc_field_gate
  import uyvy_fc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_wr_en,
  input  logic     cfg_wr_data,
  input  logic     in_acc,
  input  in_item_t in_item,
  output logic     keep
);

  logic output_enable_r;
  logic output_enable_nxt;
  logic line_is_odd_r;
  logic line_is_odd_nxt;
  logic odd_now;

  // Frame start forces an even line before the word is judged.
  assign odd_now = in_item.frame_start ? 1'b0 : line_is_odd_r;
  assign keep    = output_enable_r & ~odd_now;

  always_comb begin
    output_enable_nxt = cfg_wr_en ? cfg_wr_data : output_enable_r;
    line_is_odd_nxt   = line_is_odd_r;
    if (in_acc) begin
      line_is_odd_nxt = in_item.line_end ? ~odd_now : odd_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      output_enable_r <= 1'b1;
      line_is_odd_r   <= 1'b0;
    end else begin
      output_enable_r <= output_enable_nxt;
      line_is_odd_r   <= line_is_odd_nxt;
    end
  end

  `ASSERT_NEXT(a_fs_le_odd, in_acc && in_item.frame_start && in_item.line_end,
    line_is_odd_r, "frame start with line end must leave an odd line")
  `ASSERT_NEXT(a_fs_even, in_acc && in_item.frame_start && !in_item.line_end,
    !line_is_odd_r, "frame start without line end must leave an even line")
  `ASSERT_NEXT(a_parity_hold, !in_acc && !cfg_wr_en, $stable(line_is_odd_r),
    "line parity changed without a transaction")

endmodule

// File: hdl/uyvy_fc_pixel_conv.sv
// BT.601 studio-range YCbCr to RGB for one pixel, fixed point, floor and clamp.
// Depends on uyvy_fc_pkg.
module uyvy_fc_pixel_conv
  import uyvy_fc_pkg::*;
#(
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic [7:0] luma,
  input  logic [7:0] cb,
  input  logic [7:0] cr,
  output rgb_t       rgb
);

  // Sums stay within +-1024 in integer units (blue peaks near 535), so ten
  // magnitude bits and a sign bit above the fraction are enough.
  localparam int AW = COEF_FRAC_BITS + 11;

  localparam longint unsigned KY_L = ((longint'(1164) << COEF_FRAC_BITS) + 500) / 1000;
  localparam longint unsigned KRV_L = ((longint'(1596) << COEF_FRAC_BITS) + 500) / 1000;
  localparam longint unsigned KGV_L = ((longint'(813) << COEF_FRAC_BITS) + 500) / 1000;
  localparam longint unsigned KGU_L = ((longint'(391) << COEF_FRAC_BITS) + 500) / 1000;
  localparam longint unsigned KBU_L = ((longint'(2018) << COEF_FRAC_BITS) + 500) / 1000;

  localparam logic signed [AW-1:0] K_Y  = AW'(KY_L);
  localparam logic signed [AW-1:0] K_RV = AW'(KRV_L);
  localparam logic signed [AW-1:0] K_GV = AW'(KGV_L);
  localparam logic signed [AW-1:0] K_GU = AW'(KGU_L);
  localparam logic signed [AW-1:0] K_BU = AW'(KBU_L);

  logic signed [9:0]    y_off;
  logic signed [9:0]    cb_off;
  logic signed [9:0]    cr_off;
  logic signed [AW-1:0] y_ext;
  logic signed [AW-1:0] cb_ext;
  logic signed [AW-1:0] cr_ext;
  logic signed [AW-1:0] luma_term;
  logic signed [AW-1:0] acc_r;
  logic signed [AW-1:0] acc_g;
  logic signed [AW-1:0] acc_b;

  // Floor by dropping the fraction, then clamp to 0..255.
  function automatic logic [7:0] clamp_fixed(input logic signed [AW-1:0] acc);
    logic [7:0] res;
    if (acc[AW-1] || (acc == '0)) begin
      res = 8'd0;
    end else if (|acc[AW-2:COEF_FRAC_BITS+8]) begin
      res = 8'hFF;
    end else begin
      res = acc[COEF_FRAC_BITS+7:COEF_FRAC_BITS];
    end
    return res;
  endfunction

  always_comb begin
    y_off     = signed'({2'b00, luma}) - 10'sd16;
    cb_off    = signed'({2'b00, cb}) - 10'sd128;
    cr_off    = signed'({2'b00, cr}) - 10'sd128;
    y_ext     = AW'(y_off);
    cb_ext    = AW'(cb_off);
    cr_ext    = AW'(cr_off);
    luma_term = K_Y * y_ext;
    acc_r     = luma_term + K_RV * cr_ext;
    acc_g     = luma_term - K_GV * cr_ext - K_GU * cb_ext;
    acc_b     = luma_term + K_BU * cb_ext;
    rgb.red   = clamp_fixed(acc_r);
    rgb.green = clamp_fixed(acc_g);
    rgb.blue  = clamp_fixed(acc_b);
  end

endmodule

// File: hdl/uyvy_to_rgb_field_converter.sv
// Packed 4:2:2 (Cb Y0 Cr Y1) to 8-bit RGB converter that keeps even lines only.
// Depends on uyvy_fc_pkg, uyvy_fc_field_gate, uyvy_fc_pixel_conv, assert_macros.svh.
//
// One packed word is taken every clock unless in_stall is high, and each kept word
// produces one RGB pixel pair: it is held in the input register, then passes
// through the conversion into the result register. Words on odd lines,
// and all words while output_enable is 0, yield nothing, but frame_start and
// line_end still track line parity. The two-entry pipeline keeps accepting
// while a result waits; in_stall rises only when both stages hold data and
// out_stall is high.
`include "assert_macros.svh"

module uyvy_to_rgb_field_converter
  import uyvy_fc_pkg::*;
#(
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      in_acc;
  logic      keep;
  logic      s1_valid_r;
  logic      s1_valid_nxt;
  in_item_t  s1_item_r;
  in_item_t  s1_item_nxt;
  logic      out_valid_r;
  logic      out_valid_nxt;
  out_item_t out_data_r;
  out_item_t out_data_nxt;
  logic      s1_ready;
  logic      s2_ready;
  rgb_t      rgb_first;
  rgb_t      rgb_second;

  assign s2_ready  = ~out_valid_r | ~out_stall;
  assign s1_ready  = ~s1_valid_r | s2_ready;
  assign in_stall  = ~s1_ready;
  assign in_acc    = in_valid & s1_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  uyvy_fc_field_gate u_gate (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_acc      (in_acc),
    .in_item     (in_data),
    .keep        (keep)
  );

  uyvy_fc_pixel_conv #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_conv_first (
    .luma (s1_item_r.pixel_word[15:8]),
    .cb   (s1_item_r.pixel_word[7:0]),
    .cr   (s1_item_r.pixel_word[23:16]),
    .rgb  (rgb_first)
  );

  uyvy_fc_pixel_conv #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_conv_second (
    .luma (s1_item_r.pixel_word[31:24]),
    .cb   (s1_item_r.pixel_word[7:0]),
    .cr   (s1_item_r.pixel_word[23:16]),
    .rgb  (rgb_second)
  );

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    s1_item_nxt   = s1_item_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    // Advance the input register; dropped words never occupy it.
    if (s1_ready) begin
      s1_valid_nxt = in_acc & keep;
      if (in_acc) begin
        s1_item_nxt = in_data;
      end
    end
    if (s2_ready) begin
      out_valid_nxt = s1_valid_r;
      if (s1_valid_r) begin
        out_data_nxt.red_first    = rgb_first.red;
        out_data_nxt.green_first  = rgb_first.green;
        out_data_nxt.blue_first   = rgb_first.blue;
        out_data_nxt.red_second   = rgb_second.red;
        out_data_nxt.green_second = rgb_second.green;
        out_data_nxt.blue_second  = rgb_second.blue;
        out_data_nxt.last_of_line = s1_item_r.line_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_item_r  <= s1_item_nxt;
    out_data_r <= out_data_nxt;
  end

  `ASSERT_NEXT(a_drop_word, in_acc && !keep, !s1_valid_r,
    "dropped word entered the pipeline")
  `ASSERT_SAME(a_stall_cause, in_stall, s1_valid_r && out_valid_r && out_stall,
    "input stalled while the pipeline had room")
  `ASSERT_NEXT(a_no_loss, s1_valid_r && out_valid_r && out_stall,
    s1_valid_r && out_valid_r, "pending transaction lost under stall")
  `ASSERT_NEXT(a_fill_result, s1_valid_r && s2_ready, out_valid_r,
    "converted pair did not reach the result register")

endmodule
